>>> sv/rxs_pkg.sv
package rxs_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned SH_A       = 13;
  localparam int unsigned SH_B       = 17;
  localparam int unsigned SH_C       = 5;

  // request kinds on the func field
  localparam logic FUNC_DRAW  = 1'b0;
  localparam logic FUNC_RANGE = 1'b1;

  // direct: result known at the front; mod: back runs the remainder
  typedef enum logic {
    KIND_DIRECT,
    KIND_MOD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] base;  // final int for direct, low bound for mod
    logic [WORD_W-1:0] span;
  } job_t;

  function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = x ^ (x << SH_A);
    b = a ^ (a >> SH_B);
    c = b ^ (b << SH_C);
    return c;
  endfunction

endpackage

>>> sv/rxs_front.sv
module rxs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [rxs_pkg::WORD_W-1:0] cfg_wr_data,
  input  logic                       accept,
  input  logic                       func,
  input  logic [rxs_pkg::WORD_W-1:0] low_bound,
  input  logic [rxs_pkg::WORD_W-1:0] high_bound,
  output rxs_pkg::job_t              job
);
  import rxs_pkg::*;

  logic [WORD_W-1:0] gen_state_r;
  logic [WORD_W-1:0] gen_state_nxt;
  logic [WORD_W-1:0] adv;
  logic [WORD_W-1:0] span;
  logic              empty_range;
  logic              do_adv;

  assign adv         = xs_advance(gen_state_r);
  assign empty_range = $signed(low_bound) >= $signed(high_bound);
  assign span        = high_bound - low_bound + WORD_W'(1);
  assign do_adv      = (func == FUNC_DRAW) || !empty_range;

  always_comb begin
    job.word = do_adv ? adv : gen_state_r;
    job.span = span;
    job.kind = KIND_DIRECT;
    job.base = '0;
    if (func == FUNC_RANGE) begin
      if (empty_range) begin
        job.base = low_bound;
      end else if (span == '0) begin
        // full 32-bit span: modulo is the identity
        job.base = low_bound + adv;
      end else begin
        job.kind = KIND_MOD;
        job.base = low_bound;
      end
    end
  end

  always_comb begin
    gen_state_nxt = gen_state_r;
    if (cfg_wr_en) begin
      gen_state_nxt = (cfg_wr_data == '0) ? WORD_W'(1) : cfg_wr_data;
    end else if (accept && do_adv) begin
      gen_state_nxt = adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_state_r <= WORD_W'(1);
    end else begin
      gen_state_r <= gen_state_nxt;
    end
  end

endmodule

>>> sv/rxs_queue.sv
module rxs_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rxs_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output rxs_pkg::job_t pop_data,
  output logic          empty
);
  import rxs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> sv/rxs_back.sv
module rxs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rxs_pkg::job_t              job,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [rxs_pkg::WORD_W-1:0] out_raw_word,
  output logic [rxs_pkg::FRAC_W-1:0] out_fraction,
  output logic [rxs_pkg::WORD_W-1:0] out_int_value
);
  import rxs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  localparam int CNT_W = $clog2(WORD_W);

  state_t            state_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] raw_r;
  logic [WORD_W-1:0] int_r;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] base_r;
  logic [WORD_W-1:0] span_r;
  logic [WORD_W-1:0] dvd_r;
  logic [WORD_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              slot_free;
  logic              out_load;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_step;

  assign slot_free = !out_valid_r || out_pop;
  assign job_pop   = (state_r == S_IDLE) && !job_empty &&
                     ((job.kind == KIND_MOD) || slot_free);

  // result register takes a new beat this cycle
  assign out_load  = (job_pop && (job.kind == KIND_DIRECT)) ||
                     ((state_r == S_DONE) && slot_free);

  // one restoring step of the remainder
  assign trial    = {rem_r, dvd_r[WORD_W-1]};
  assign diff     = trial - {1'b0, span_r};
  assign rem_step = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];

  assign out_empty     = !out_valid_r;
  assign out_raw_word  = raw_r;
  assign out_fraction  = raw_r[FRAC_SHIFT +: FRAC_W];
  assign out_int_value = int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_pop) begin
            if (job.kind == KIND_DIRECT) begin
              raw_r <= job.word;
              int_r <= job.base;
            end else begin
              word_r  <= job.word;
              base_r  <= job.base;
              span_r  <= job.span;
              dvd_r   <= job.word;
              rem_r   <= '0;
              cnt_r   <= CNT_W'(WORD_W - 1);
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= rem_step;
          dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            raw_r   <= word_r;
            int_r   <= base_r + rem_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/xorshift32_random_draw.sv
// xorshift32 random source (shifts 13, 17, 5) behind queue-style ports. writing
// cfg_wr_data with cfg_wr_en loads the generator state at once (a zero seed
// loads 1). each beat pushed on the input gives exactly one result beat: func 0
// advances the state and returns the new word and its top 24 bits as a Q0.24
// fraction; func 1 returns low + word mod (high-low+1), with low returned and
// the state left alone when low >= high, and the full 32-bit span taken as the
// identity. draws, empty ranges and full spans are written straight into the
// back end's result register; a range request that needs the modulo runs the
// bit-serial restoring remainder unit (one bit per cycle over 32 bits) first.
// the front end advances the state and classifies each request without waiting
// for the remainder, so up to QUEUE_DEPTH requests wait in the job queue
module xorshift32_random_draw #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: seed write
  input  logic               cfg_wr_en,
  input  logic        [31:0] cfg_wr_data,
  // request beats
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  // result beats
  output logic               out_empty,
  input  logic               out_pop,
  output logic        [31:0] out_raw_word,
  output logic        [23:0] out_fraction,
  output logic signed [31:0] out_int_value
);
  import rxs_pkg::*;

  job_t job_in;
  job_t job_out;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;

  // a beat is taken only while the job queue has room
  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  // front: generator state and request classification
  rxs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .func        (in_func),
    .low_bound   (in_low_bound),
    .high_bound  (in_high_bound),
    .job         (job_in)
  );

  // short job queue between front and back
  rxs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (job_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (job_out),
    .empty     (q_empty)
  );

  // back: remainder unit and result register
  rxs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (job_out),
    .job_empty     (q_empty),
    .job_pop       (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_raw_word  (out_raw_word),
    .out_fraction  (out_fraction),
    .out_int_value (out_int_value)
  );

endmodule
